### hw/rtl/xsm_pkg.sv
// Shared types, constants and field arithmetic for the X25519 scalar multiply unit.
// Used by xsm_regfile, xsm_fieldalu and x25519_scalar_multiply_unit; no dependencies.
`timescale 1ns / 1ps

package xsm_pkg;

  localparam int unsigned FeWidth   = 255;
  localparam int unsigned NumRegs   = 8;
  localparam int unsigned RegAddrW  = 3;
  localparam int unsigned LadderOps = 18;

  // p = 2^255 - 19
  localparam logic [FeWidth-1:0] FieldP = {{(FeWidth-5){1'b1}}, 5'b01101};
  localparam logic [FeWidth-1:0] FeOne  = FeWidth'(1);
  localparam logic [FeWidth-1:0] FeA24  = FeWidth'(121665);

  localparam logic [1:0] CmdLoadScalar = 2'd0;
  localparam logic [1:0] CmdLoadPoint  = 2'd1;
  localparam logic [1:0] CmdStart      = 2'd2;

  // Working registers: A..D take part in the ladder swaps, K holds a24.
  localparam logic [RegAddrW-1:0] RegA = 3'd0;
  localparam logic [RegAddrW-1:0] RegB = 3'd1;
  localparam logic [RegAddrW-1:0] RegC = 3'd2;
  localparam logic [RegAddrW-1:0] RegD = 3'd3;
  localparam logic [RegAddrW-1:0] RegE = 3'd4;
  localparam logic [RegAddrW-1:0] RegF = 3'd5;
  localparam logic [RegAddrW-1:0] RegX = 3'd6;
  localparam logic [RegAddrW-1:0] RegK = 3'd7;

  typedef enum logic [1:0] {
    OpAdd,
    OpSub,
    OpMul,
    OpMov
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [RegAddrW-1:0] dst;
    logic [RegAddrW-1:0] src1;
    logic [RegAddrW-1:0] src2;
  } uop_t;

  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

  typedef struct packed {
    logic                en;
    logic [RegAddrW-1:0] addr;
    logic [FeWidth-1:0]  data;
  } rf_wr_t;

  // Modular add of two canonical elements.
  function automatic logic [FeWidth-1:0] fe_add(logic [FeWidth-1:0] a, logic [FeWidth-1:0] b);
    logic [FeWidth:0]   s;
    logic [FeWidth+1:0] t;
    s = {1'b0, a} + {1'b0, b};
    t = {1'b0, s} - {2'b00, FieldP};
    return t[FeWidth+1] ? s[FeWidth-1:0] : t[FeWidth-1:0];
  endfunction

  // Modular subtract of two canonical elements.
  function automatic logic [FeWidth-1:0] fe_sub(logic [FeWidth-1:0] a, logic [FeWidth-1:0] b);
    logic [FeWidth:0] t;
    t = {1'b0, a} - {1'b0, b};
    return t[FeWidth] ? (t[FeWidth-1:0] + FieldP) : t[FeWidth-1:0];
  endfunction

  // One ladder step, with the swaps folded into register renaming.
  function automatic uop_t ladder_uop(logic [4:0] idx);
    uop_t u;
    unique case (idx)
      5'd0:  u = '{OpAdd, RegE, RegA, RegC};
      5'd1:  u = '{OpSub, RegA, RegA, RegC};
      5'd2:  u = '{OpAdd, RegC, RegB, RegD};
      5'd3:  u = '{OpSub, RegB, RegB, RegD};
      5'd4:  u = '{OpMul, RegD, RegE, RegE};
      5'd5:  u = '{OpMul, RegF, RegA, RegA};
      5'd6:  u = '{OpMul, RegA, RegC, RegA};
      5'd7:  u = '{OpMul, RegC, RegB, RegE};
      5'd8:  u = '{OpAdd, RegE, RegA, RegC};
      5'd9:  u = '{OpSub, RegA, RegA, RegC};
      5'd10: u = '{OpMul, RegB, RegA, RegA};
      5'd11: u = '{OpSub, RegC, RegD, RegF};
      5'd12: u = '{OpMul, RegA, RegC, RegK};
      5'd13: u = '{OpAdd, RegA, RegA, RegD};
      5'd14: u = '{OpMul, RegC, RegC, RegA};
      5'd15: u = '{OpMul, RegA, RegD, RegF};
      5'd16: u = '{OpMul, RegD, RegB, RegX};
      5'd17: u = '{OpMul, RegB, RegE, RegE};
      default: u = '{OpMov, RegE, RegE, RegE};
    endcase
    return u;
  endfunction

endpackage

### hw/rtl/xsm_regfile.sv
// Working register file of field elements: one write port, two registered read ports.
// Depends on xsm_pkg.
`timescale 1ns / 1ps

module xsm_regfile (
  input  logic                           clk_i,
  input  xsm_pkg::rf_wr_t                wr_i,
  input  logic [xsm_pkg::RegAddrW-1:0]   raddr_a_i,
  input  logic [xsm_pkg::RegAddrW-1:0]   raddr_b_i,
  output logic [xsm_pkg::FeWidth-1:0]    rdata_a_o,
  output logic [xsm_pkg::FeWidth-1:0]    rdata_b_o
);

  logic [xsm_pkg::FeWidth-1:0] mem [xsm_pkg::NumRegs];
  logic [xsm_pkg::FeWidth-1:0] rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### hw/rtl/xsm_fieldalu.sv
// Field arithmetic unit mod 2^255-19: add, subtract and move with a registered result, and a
// bit-serial multiplier that consumes one multiplier bit per cycle. Depends on xsm_pkg.
`timescale 1ns / 1ps

module xsm_fieldalu (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  xsm_pkg::alu_req_t           req_i,
  input  logic [xsm_pkg::FeWidth-1:0] opa_i,
  input  logic [xsm_pkg::FeWidth-1:0] opb_i,
  output logic                        done_o,
  output logic [xsm_pkg::FeWidth-1:0] result_o
);

  logic                        busy_q, done_q;
  logic [7:0]                  cnt_q;
  logic [xsm_pkg::FeWidth-1:0] a_q, b_q, acc_q;
  logic [xsm_pkg::FeWidth+1:0] sum;
  logic [xsm_pkg::FeWidth+2:0] diff1, diff2;
  logic [xsm_pkg::FeWidth-1:0] step_d;

  // Horner step, MSB first: acc = 2*acc + bit*a. The sum stays below 3p, so the
  // subtractions of p and 2p are formed side by side and the right one is picked.
  always_comb begin
    sum    = {1'b0, acc_q, 1'b0}
           + {2'b00, a_q & {xsm_pkg::FeWidth{b_q[xsm_pkg::FeWidth-1]}}};
    diff1  = {1'b0, sum} - {3'b000, xsm_pkg::FieldP};
    diff2  = {1'b0, sum} - {2'b00, xsm_pkg::FieldP, 1'b0};
    step_d = !diff2[xsm_pkg::FeWidth+2] ? diff2[xsm_pkg::FeWidth-1:0] :
             !diff1[xsm_pkg::FeWidth+2] ? diff1[xsm_pkg::FeWidth-1:0] :
                                          sum[xsm_pkg::FeWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        case (req_i.op)
          xsm_pkg::OpAdd: begin
            acc_q  <= xsm_pkg::fe_add(opa_i, opb_i);
            done_q <= 1'b1;
          end
          xsm_pkg::OpSub: begin
            acc_q  <= xsm_pkg::fe_sub(opa_i, opb_i);
            done_q <= 1'b1;
          end
          xsm_pkg::OpMov: begin
            acc_q  <= opa_i;
            done_q <= 1'b1;
          end
          default: begin
            a_q    <= opa_i;
            b_q    <= opb_i;
            acc_q  <= '0;
            cnt_q  <= 8'(xsm_pkg::FeWidth - 1);
            busy_q <= 1'b1;
          end
        endcase
      end else if (busy_q) begin
        acc_q <= step_d;
        b_q   <= {b_q[xsm_pkg::FeWidth-2:0], 1'b0};
        if (cnt_q == 8'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 8'd1;
        end
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = acc_q;

endmodule

### hw/rtl/x25519_scalar_multiply_unit.sv
// X25519 scalar multiply unit: operand stores, ladder and inversion sequencer, result output.
// Depends on xsm_pkg, xsm_regfile and xsm_fieldalu.
//
// Usage: requests arrive on the input channel (in_valid_i / in_ready_o). A load-scalar or
// load-point request writes one 64-bit word of the operand stores and leaves the unit idle.
// A start request clamps the scalar, masks and reduces the point, and runs a 255-step
// Montgomery ladder, an inversion by exponent p-2 and a final multiply. The four
// little-endian result words then leave on the output channel (out_valid_o / out_ready_i),
// with last_o on the fourth. Unknown commands are taken and ignored.
// Each field multiply walks the 255 bits of its second operand one per cycle on the single
// shared multiplier, and 10 of the 18 operations of each ladder step and all 506 inversion
// operations after the initial copy are multiplies. While a start runs or results wait, no
// new request is taken; a stalled receiver simply holds the current result word. Reset clears
// the operand stores and the sequencer.
`timescale 1ns / 1ps

module x25519_scalar_multiply_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [1:0]  word_index_i,
  input  logic [63:0] word_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_word_o,
  output logic [1:0]  result_index_o,
  output logic        last_o
);

  typedef enum logic [2:0] {
    StIdle, StInit, StRead, StExec, StWait, StFetch, StCapture, StOut
  } state_e;

  typedef enum logic [1:0] {
    PhLadder, PhCopy, PhInv, PhFinal
  } phase_e;

  state_e                      state_q;
  phase_e                      phase_q;
  logic [63:0]                 scalar_q [4];
  logic [63:0]                 point_q [4];
  logic [7:0]                  pos_q;
  logic [4:0]                  uidx_q;
  logic [7:0]                  inv_i_q;
  logic                        inv_sub_q;
  logic [2:0]                  init_cnt_q;
  logic [1:0]                  oidx_q;
  logic [xsm_pkg::FeWidth-1:0] res_q;

  logic [255:0]                kvec;
  logic                        kbit, swap;
  logic [xsm_pkg::FeWidth-1:0] point_red;
  xsm_pkg::uop_t               uop;
  logic [xsm_pkg::RegAddrW-1:0] dst_p, src1_p, src2_p, raddr_a;
  xsm_pkg::rf_wr_t             wr;
  xsm_pkg::alu_req_t           alu_req;
  logic [xsm_pkg::FeWidth-1:0] rdata_a, rdata_b, alu_res;
  logic                        alu_done;
  logic [255:0]                res_full;
  logic                        in_acc;

  function automatic logic [xsm_pkg::RegAddrW-1:0] phys(logic [xsm_pkg::RegAddrW-1:0] r,
                                                         logic s);
    return r[2] ? r : {r[2:1], r[0] ^ s};
  endfunction

  assign in_acc = in_valid_i && in_ready_o;

  always_comb begin
    kvec = {scalar_q[3], scalar_q[2], scalar_q[1], scalar_q[0]};
    kvec[2:0] = 3'b000;
    kvec[255] = 1'b0;
    kvec[254] = 1'b1;
    kbit = kvec[pos_q];
    point_red = xsm_pkg::fe_add({point_q[3][62:0], point_q[2], point_q[1], point_q[0]}, '0);
  end

  always_comb begin
    swap = 1'b0;
    case (phase_q)
      PhLadder: begin
        uop  = xsm_pkg::ladder_uop(uidx_q);
        swap = kbit;
      end
      PhCopy:  uop = '{xsm_pkg::OpMov, xsm_pkg::RegE, xsm_pkg::RegC, xsm_pkg::RegC};
      PhInv: begin
        if (inv_sub_q) begin
          uop = '{xsm_pkg::OpMul, xsm_pkg::RegE, xsm_pkg::RegE, xsm_pkg::RegC};
        end else begin
          uop = '{xsm_pkg::OpMul, xsm_pkg::RegE, xsm_pkg::RegE, xsm_pkg::RegE};
        end
      end
      default: uop = '{xsm_pkg::OpMul, xsm_pkg::RegA, xsm_pkg::RegA, xsm_pkg::RegE};
    endcase
    dst_p   = phys(uop.dst, swap);
    src1_p  = phys(uop.src1, swap);
    src2_p  = phys(uop.src2, swap);
    raddr_a = (state_q == StFetch) ? xsm_pkg::RegA : src1_p;
  end

  always_comb begin
    wr = '0;
    if (state_q == StInit) begin
      wr.en = 1'b1;
      unique case (init_cnt_q)
        3'd0:    begin wr.addr = xsm_pkg::RegX; wr.data = point_red;     end
        3'd1:    begin wr.addr = xsm_pkg::RegB; wr.data = point_red;     end
        3'd2:    begin wr.addr = xsm_pkg::RegA; wr.data = xsm_pkg::FeOne; end
        3'd3:    begin wr.addr = xsm_pkg::RegC; wr.data = '0;            end
        3'd4:    begin wr.addr = xsm_pkg::RegD; wr.data = xsm_pkg::FeOne; end
        default: begin wr.addr = xsm_pkg::RegK; wr.data = xsm_pkg::FeA24; end
      endcase
    end else if (state_q == StWait && alu_done) begin
      wr.en   = 1'b1;
      wr.addr = dst_p;
      wr.data = alu_res;
    end
    alu_req.start = (state_q == StExec);
    alu_req.op    = uop.op;
  end

  xsm_regfile u_regfile (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .raddr_a_i (raddr_a),
    .raddr_b_i (src2_p),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  xsm_fieldalu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .opa_i    (rdata_a),
    .opb_i    (rdata_b),
    .done_o   (alu_done),
    .result_o (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      phase_q    <= PhLadder;
      pos_q      <= '0;
      uidx_q     <= '0;
      inv_i_q    <= '0;
      inv_sub_q  <= 1'b0;
      init_cnt_q <= '0;
      oidx_q     <= '0;
      for (int i = 0; i < 4; i++) begin
        scalar_q[i] <= '0;
        point_q[i]  <= '0;
      end
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            case (command_i)
              xsm_pkg::CmdLoadScalar: scalar_q[word_index_i] <= word_value_i;
              xsm_pkg::CmdLoadPoint:  point_q[word_index_i]  <= word_value_i;
              xsm_pkg::CmdStart: begin
                state_q    <= StInit;
                init_cnt_q <= '0;
                phase_q    <= PhLadder;
                pos_q      <= 8'd254;
                uidx_q     <= '0;
              end
              default: ;
            endcase
          end
        end
        StInit: begin
          if (init_cnt_q == 3'd5) begin
            state_q <= StRead;
          end
          init_cnt_q <= init_cnt_q + 3'd1;
        end
        StRead: state_q <= StExec;
        StExec: state_q <= StWait;
        StWait: begin
          if (alu_done) begin
            state_q <= StRead;
            case (phase_q)
              PhLadder: begin
                if (uidx_q == 5'(xsm_pkg::LadderOps - 1)) begin
                  uidx_q <= '0;
                  if (pos_q == 8'd0) begin
                    phase_q <= PhCopy;
                  end else begin
                    pos_q <= pos_q - 8'd1;
                  end
                end else begin
                  uidx_q <= uidx_q + 5'd1;
                end
              end
              PhCopy: begin
                phase_q   <= PhInv;
                inv_i_q   <= 8'd253;
                inv_sub_q <= 1'b0;
              end
              PhInv: begin
                // Exponent p-2 has zero bits at positions two and four only.
                if (!inv_sub_q && inv_i_q != 8'd2 && inv_i_q != 8'd4) begin
                  inv_sub_q <= 1'b1;
                end else begin
                  inv_sub_q <= 1'b0;
                  if (inv_i_q == 8'd0) begin
                    phase_q <= PhFinal;
                  end else begin
                    inv_i_q <= inv_i_q - 8'd1;
                  end
                end
              end
              default: state_q <= StFetch;
            endcase
          end
        end
        StFetch:   state_q <= StCapture;
        StCapture: begin
          res_q   <= rdata_a;
          oidx_q  <= '0;
          state_q <= StOut;
        end
        StOut: begin
          if (out_ready_i) begin
            oidx_q <= oidx_q + 2'd1;
            if (oidx_q == 2'd3) begin
              state_q <= StIdle;
              phase_q <= PhLadder;
              pos_q   <= '0;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign res_full       = {1'b0, res_q};
  assign in_ready_o     = (state_q == StIdle);
  assign out_valid_o    = (state_q == StOut);
  assign result_word_o  = res_full[{oidx_q, 6'd0} +: 64];
  assign result_index_o = oidx_q;
  assign last_o         = (oidx_q == 2'd3);

endmodule
